// ===== rtl/core/fpqs_pkg.sv =====
// Shared types and constants for the four-level priority queue scheduler.
// Used by the channel interfaces and by every module in rtl/core.
package fpqs_pkg;

	localparam int NUM_QUEUES = 4;
	localparam int QW         = 2;

	// Queue index of priority level 3, the level that drains completely
	localparam logic [QW-1:0] Q_LEVEL3 = 2'd2;

	typedef enum logic [0:0] {
		OP_ENQ     = 1'b0,
		OP_SERVICE = 1'b1
	} op_e;

	typedef enum logic [2:0] {
		ST_ENQUEUED = 3'd0,
		ST_FULL     = 3'd1,
		ST_BAD_PRIO = 3'd2,
		ST_SERVED   = 3'd3,
		ST_EMPTY    = 3'd4
	} status_e;

	typedef enum logic [0:0] {
		S_IDLE = 1'b0,
		S_READ = 1'b1
	} fsm_e;

	typedef struct packed {
		op_e         op;
		logic [2:0]  priority_req;
		logic [1:0]  display_type;
		logic        refresh_mode;
		logic [7:0]  x_pos;
		logic [7:0]  y_pos;
		logic [15:0] content_handle;
	} req_t;

	typedef struct packed {
		status_e     status;
		logic [2:0]  served_priority;
		logic [1:0]  out_type;
		logic        out_mode;
		logic [7:0]  out_x;
		logic [7:0]  out_y;
		logic [15:0] out_handle;
		logic        switch_refresh;
		logic        last;
	} rsp_t;

	// One stored display request, 35 bits
	typedef struct packed {
		logic [1:0]  dtype;
		logic        mode;
		logic [7:0]  x;
		logic [7:0]  y;
		logic [15:0] handle;
	} entry_t;

	// Pointer file command: one push or one pop per cycle on queue q
	typedef struct packed {
		logic          push;
		logic          pop;
		logic [QW-1:0] q;
	} ptr_cmd_t;

endpackage

// ===== rtl/core/fpqs_req_if.sv =====
// Request channel: valid/ready handshake carrying one request word.
// Depends on fpqs_pkg for the payload type.
interface fpqs_req_if;
	logic           valid;
	logic           ready;
	fpqs_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/fpqs_rsp_if.sv =====
// Result channel: valid/ready handshake carrying one result word.
// Depends on fpqs_pkg for the payload type.
interface fpqs_rsp_if;
	logic           valid;
	logic           ready;
	fpqs_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/fpqs_entry_ram.sv =====
// Entry store: one write port, one read port, registered read data.
// Depends on fpqs_pkg for the entry type.
module fpqs_entry_ram #(
	parameter int AW = 5
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  fpqs_pkg::entry_t wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output fpqs_pkg::entry_t rdata
);

	fpqs_pkg::entry_t mem [(1 << AW)];
	fpqs_pkg::entry_t rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/fpqs_ptr_file.sv =====
// Ring pointers and fill counts of the four queues, with empty/full flags.
// Depends on fpqs_pkg for the command struct.
module fpqs_ptr_file #(
	parameter int QUEUE_DEPTH = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  fpqs_pkg::ptr_cmd_t                 cmd,
	input  logic [fpqs_pkg::QW-1:0]            q_sel,
	output logic [$clog2(QUEUE_DEPTH)-1:0]     rd_ptr,
	output logic [$clog2(QUEUE_DEPTH)-1:0]     wr_ptr,
	output logic [fpqs_pkg::NUM_QUEUES-1:0]    empty,
	output logic [fpqs_pkg::NUM_QUEUES-1:0]    full
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PW-1:0] PTR_MAX = PW'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] CNT_MAX = CW'(QUEUE_DEPTH);

	logic [PW-1:0] rd_ptr_q [fpqs_pkg::NUM_QUEUES];
	logic [PW-1:0] wr_ptr_q [fpqs_pkg::NUM_QUEUES];
	logic [CW-1:0] cnt_q    [fpqs_pkg::NUM_QUEUES];

	// advance pointers and counts on push or pop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < fpqs_pkg::NUM_QUEUES; i++) begin
				rd_ptr_q[i] <= '0;
				wr_ptr_q[i] <= '0;
				cnt_q[i]    <= '0;
			end
		end else begin
			if (cmd.push) begin
				wr_ptr_q[cmd.q] <= (wr_ptr_q[cmd.q] == PTR_MAX) ? '0 : wr_ptr_q[cmd.q] + 1'b1;
				cnt_q[cmd.q]    <= cnt_q[cmd.q] + 1'b1;
			end else if (cmd.pop) begin
				rd_ptr_q[cmd.q] <= (rd_ptr_q[cmd.q] == PTR_MAX) ? '0 : rd_ptr_q[cmd.q] + 1'b1;
				cnt_q[cmd.q]    <= cnt_q[cmd.q] - 1'b1;
			end
		end
	end

	// flags per queue
	always_comb begin
		for (int i = 0; i < fpqs_pkg::NUM_QUEUES; i++) begin
			empty[i] = (cnt_q[i] == '0);
			full[i]  = (cnt_q[i] == CNT_MAX);
		end
	end

	assign rd_ptr = rd_ptr_q[q_sel];
	assign wr_ptr = wr_ptr_q[q_sel];

endmodule

// ===== rtl/core/four_level_priority_queue_scheduler.sv =====
// Top level of the four-level strict priority queue scheduler.
// Depends on fpqs_pkg, fpqs_req_if, fpqs_rsp_if, fpqs_entry_ram, fpqs_ptr_file.
//
//   Port   Dir   Handshake      Word
//   req    in    valid/ready    op, priority, type, mode, x, y, handle
//   rsp    out   valid/ready    status, level, entry fields, switch, last
//
// An enqueue's result sits in the output register in the cycle after accept. A service
// reads the entry memory, whose read data is registered; from S_READ its first result
// enters the output register once that register is free. A level 3 drain then yields
// one result per cycle while results are taken, paced by the single memory read port.
// req.ready is low until the last result of the current word is in the output
// register, and low whenever a held result is not taken. Reset clears all queues.
module four_level_priority_queue_scheduler #(
	parameter int QUEUE_DEPTH = 8
) (
	input logic         clk,
	input logic         arst_n,
	fpqs_req_if.sink    req,
	fpqs_rsp_if.source  rsp
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int AW = fpqs_pkg::QW + PW;

	fpqs_pkg::fsm_e                     state_q, state_d;
	logic [fpqs_pkg::QW-1:0]            qsel_q, qsel_d;
	logic                               first_q, first_d;
	logic                               last_mode_q, last_mode_d;
	logic                               out_vld_q;
	fpqs_pkg::rsp_t                     rsp_q, rsp_d;
	logic                               ld_out;

	fpqs_pkg::ptr_cmd_t                 cmd;
	logic [fpqs_pkg::QW-1:0]            q_sel;
	logic [PW-1:0]                      rd_ptr, wr_ptr;
	logic [fpqs_pkg::NUM_QUEUES-1:0]    empty, full;

	logic                               mem_we, mem_re;
	fpqs_pkg::entry_t                   wdata, rdata;

	logic                               out_free, accept, prio_ok, more;
	logic [fpqs_pkg::QW-1:0]            enq_q, svc_q;

	fpqs_ptr_file #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_ptrs (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.q_sel  (q_sel),
		.rd_ptr (rd_ptr),
		.wr_ptr (wr_ptr),
		.empty  (empty),
		.full   (full)
	);

	fpqs_entry_ram #(.AW(AW)) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr ({q_sel, wr_ptr}),
		.wdata (wdata),
		.re    (mem_re),
		.raddr ({q_sel, rd_ptr}),
		.rdata (rdata)
	);

	// decode the incoming word
	assign out_free = !out_vld_q || rsp.ready;
	assign req.ready = (state_q == fpqs_pkg::S_IDLE) && out_free;
	assign accept = req.valid && req.ready;
	assign prio_ok = req.data.priority_req inside {[3'd1:3'd4]};
	assign enq_q = fpqs_pkg::QW'(req.data.priority_req - 3'd1);
	assign wdata = '{dtype:  req.data.display_type,
	                 mode:   req.data.refresh_mode,
	                 x:      req.data.x_pos,
	                 y:      req.data.y_pos,
	                 handle: req.data.content_handle};

	// pick the highest nonempty level
	always_comb begin
		if (!empty[3]) begin
			svc_q = 2'd3;
		end else if (!empty[2]) begin
			svc_q = 2'd2;
		end else if (!empty[1]) begin
			svc_q = 2'd1;
		end else begin
			svc_q = 2'd0;
		end
	end

	// level 3 keeps draining while entries remain after the last pop
	assign more = (qsel_q == fpqs_pkg::Q_LEVEL3) && !empty[qsel_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fpqs_pkg::S_IDLE;
			qsel_q      <= '0;
			first_q     <= 1'b0;
			last_mode_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			qsel_q      <= qsel_d;
			first_q     <= first_d;
			last_mode_q <= last_mode_d;
		end
	end

	// next state, memory and pointer commands, result word
	always_comb begin
		state_d     = state_q;
		qsel_d      = qsel_q;
		first_d     = first_q;
		last_mode_d = last_mode_q;
		ld_out      = 1'b0;
		rsp_d       = '0;
		rsp_d.last  = 1'b1;
		cmd         = '0;
		mem_we      = 1'b0;
		mem_re      = 1'b0;
		q_sel       = qsel_q;
		case (state_q)
			fpqs_pkg::S_IDLE: begin
				q_sel = (req.data.op == fpqs_pkg::OP_ENQ) ? enq_q : svc_q;
				if (accept) begin
					if (req.data.op == fpqs_pkg::OP_ENQ) begin
						ld_out = 1'b1;
						if (!prio_ok) begin
							rsp_d.status = fpqs_pkg::ST_BAD_PRIO;
						end else if (full[enq_q]) begin
							rsp_d.status = fpqs_pkg::ST_FULL;
						end else begin
							rsp_d.status = fpqs_pkg::ST_ENQUEUED;
							mem_we       = 1'b1;
							cmd.push     = 1'b1;
							cmd.q        = enq_q;
						end
					end else if (&empty) begin
						ld_out       = 1'b1;
						rsp_d.status = fpqs_pkg::ST_EMPTY;
					end else begin
						mem_re  = 1'b1;
						cmd.pop = 1'b1;
						cmd.q   = svc_q;
						qsel_d  = svc_q;
						first_d = 1'b1;
						state_d = fpqs_pkg::S_READ;
					end
				end
			end
			fpqs_pkg::S_READ: begin
				if (out_free) begin
					ld_out                = 1'b1;
					rsp_d.status          = fpqs_pkg::ST_SERVED;
					rsp_d.served_priority = {1'b0, qsel_q} + 3'd1;
					rsp_d.out_type        = rdata.dtype;
					rsp_d.out_mode        = rdata.mode;
					rsp_d.out_x           = rdata.x;
					rsp_d.out_y           = rdata.y;
					rsp_d.out_handle      = rdata.handle;
					rsp_d.switch_refresh  = first_q && (rdata.mode != last_mode_q);
					rsp_d.last            = !more;
					if (first_q) begin
						last_mode_d = rdata.mode;
					end
					first_d = 1'b0;
					if (more) begin
						mem_re  = 1'b1;
						cmd.pop = 1'b1;
						cmd.q   = qsel_q;
					end else begin
						state_d = fpqs_pkg::S_IDLE;
					end
				end
			end
			default: begin
				state_d = fpqs_pkg::S_IDLE;
			end
		endcase
	end

	// output register: load a new word, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (ld_out) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_out) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp.valid = out_vld_q;
	assign rsp.data  = rsp_q;

	// a new word only enters while no earlier one is still in flight
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |-> state_q == fpqs_pkg::S_IDLE)
		else $error("request accepted during a service read");

	// switch flag only ever rides on a served entry
	a_switch_served: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && rsp_q.switch_refresh |-> rsp_q.status == fpqs_pkg::ST_SERVED)
		else $error("switch_refresh on a result without an entry");

	// only level 3 gives more than one result
	a_single_pop: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && rsp_q.status == fpqs_pkg::ST_SERVED && rsp_q.served_priority != 3'd3
		|-> rsp_q.last)
		else $error("non-drain level served without last");

	// the output register is never overwritten while a word is held
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && !rsp.ready |-> !ld_out)
		else $error("held result overwritten");

endmodule

// ===== dv/four_level_priority_queue_scheduler_tb.sv =====
// Self-checking testbench for the four-level strict priority queue scheduler.
// Drives request words, predicts result words and checks them on the rsp channel.
// Depends on fpqs_pkg, fpqs_req_if, fpqs_rsp_if and four_level_priority_queue_scheduler.
module four_level_priority_queue_scheduler_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH          = 8;
	localparam int MIN_LEVEL      = 1;
	localparam int MAX_LEVEL      = fpqs_pkg::NUM_QUEUES;
	localparam int SETTLE_CYCLES  = 20;
	localparam int WATCHDOG_LIMIT = 2000;

	logic clk;
	logic arst_n;

	fpqs_req_if req_ch ();
	fpqs_rsp_if rsp_ch ();

	four_level_priority_queue_scheduler #(
		.QUEUE_DEPTH(DEPTH)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// Scheduler image kept by the testbench
	fpqs_pkg::entry_t queue_mem [fpqs_pkg::NUM_QUEUES][DEPTH];
	int     head_ptr  [fpqs_pkg::NUM_QUEUES];
	int     tail_ptr  [fpqs_pkg::NUM_QUEUES];
	int     occupancy [fpqs_pkg::NUM_QUEUES];
	logic   last_mode;

	fpqs_pkg::rsp_t pending_results[$];

	int error_count;
	int words_sent;
	int results_checked;
	int level3_drains;
	int full_rejects;
	int idle_cycles;
	int req_gap_pct;
	int rsp_stall_pct;

	// Free-running clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Pick an idle length: mostly short, now and then long
	function automatic int gap_length();
		if ($urandom_range(9) == 0)
			return $urandom_range(30, 8);
		return $urandom_range(3, 1);
	endfunction

	// Compute the result words that one accepted request word causes
	task automatic predict_schedule(input fpqs_pkg::req_t w);
		fpqs_pkg::rsp_t   r;
		fpqs_pkg::entry_t e;
		int     qi;
		int     n;
		bit     more;
		r = '0;
		r.last = 1'b1;
		if (w.op == fpqs_pkg::OP_ENQ) begin
			if (w.priority_req < MIN_LEVEL || w.priority_req > MAX_LEVEL) begin
				r.status = fpqs_pkg::ST_BAD_PRIO;
			end else begin
				qi = w.priority_req - 1;
				if (occupancy[qi] >= DEPTH) begin
					r.status = fpqs_pkg::ST_FULL;
					full_rejects++;
				end else begin
					e.dtype  = w.display_type;
					e.mode   = w.refresh_mode;
					e.x      = w.x_pos;
					e.y      = w.y_pos;
					e.handle = w.content_handle;
					queue_mem[qi][tail_ptr[qi]] = e;
					tail_ptr[qi] = (tail_ptr[qi] + 1) % DEPTH;
					occupancy[qi]++;
					r.status = fpqs_pkg::ST_ENQUEUED;
				end
			end
			pending_results.push_back(r);
			return;
		end
		// Serve the highest non-empty level; level 3 drains completely
		for (qi = fpqs_pkg::NUM_QUEUES - 1; qi >= 0; qi--) begin
			if (occupancy[qi] != 0) begin
				if (qi == fpqs_pkg::Q_LEVEL3)
					level3_drains++;
				n = 0;
				do begin
					e = queue_mem[qi][head_ptr[qi]];
					head_ptr[qi] = (head_ptr[qi] + 1) % DEPTH;
					occupancy[qi]--;
					r = '0;
					r.status          = fpqs_pkg::ST_SERVED;
					r.served_priority = 3'(qi + 1);
					r.out_type        = e.dtype;
					r.out_mode        = e.mode;
					r.out_x           = e.x;
					r.out_y           = e.y;
					r.out_handle      = e.handle;
					if (n == 0) begin
						r.switch_refresh = (e.mode != last_mode);
						last_mode = e.mode;
					end
					more = (qi == fpqs_pkg::Q_LEVEL3) && (occupancy[qi] > 0);
					r.last = !more;
					pending_results.push_back(r);
					n++;
				end while (more && n < DEPTH);
				return;
			end
		end
		r.status = fpqs_pkg::ST_EMPTY;
		pending_results.push_back(r);
	endtask

	// Send one word: optional gap, then hold valid until accepted
	task automatic send_word(input fpqs_pkg::req_t w);
		int gap;
		gap = ($urandom_range(99) < req_gap_pct) ? gap_length() : 0;
		@(negedge clk);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data  <= w;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		predict_schedule(w);
		words_sent++;
	endtask

	// Drop valid and hold off until every expected result has arrived
	task automatic wait_drained();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic fpqs_pkg::req_t enq_word(int prio, int dtype, bit mode, int x, int y,
		int h);
		fpqs_pkg::req_t w;
		w.op             = fpqs_pkg::OP_ENQ;
		w.priority_req   = 3'(prio);
		w.display_type   = 2'(dtype);
		w.refresh_mode   = mode;
		w.x_pos          = 8'(x);
		w.y_pos          = 8'(y);
		w.content_handle = 16'(h);
		return w;
	endfunction

	function automatic fpqs_pkg::req_t service_word();
		fpqs_pkg::req_t w;
		w = '0;
		w.op = fpqs_pkg::OP_SERVICE;
		return w;
	endfunction

	function automatic fpqs_pkg::req_t random_word(int enq_pct);
		fpqs_pkg::req_t w;
		w.op = ($urandom_range(99) < enq_pct) ? fpqs_pkg::OP_ENQ : fpqs_pkg::OP_SERVICE;
		if ($urandom_range(99) < 85)
			w.priority_req = 3'($urandom_range(MAX_LEVEL, MIN_LEVEL));
		else
			w.priority_req = 3'($urandom_range(7, 0));
		w.display_type   = 2'($urandom_range(3, 0));
		w.refresh_mode   = 1'($urandom_range(1, 0));
		w.x_pos          = 8'($urandom_range(255, 0));
		w.y_pos          = 8'($urandom_range(255, 0));
		w.content_handle = 16'($urandom_range(65535, 0));
		return w;
	endfunction

	// Service on empty queues and enqueues with out-of-range priority
	task automatic test_empty_and_bad_priority();
		send_word(service_word());
		send_word(enq_word(0, 3, 1'b1, 255, 255, 16'hFFFF));
		send_word(enq_word(5, 0, 1'b0, 0, 0, 0));
		send_word(enq_word(6, 1, 1'b1, 8'hAA, 8'h55, 16'hA5A5));
		send_word(enq_word(7, 2, 1'b0, 8'h55, 8'hAA, 16'h5A5A));
	endtask

	// Strict order 4, 2, 1 with refresh mode switches
	task automatic test_strict_order();
		send_word(enq_word(1, 0, 1'b0, 0, 0, 16'h0000));
		send_word(enq_word(2, 2, 1'b1, 8'h80, 8'h7F, 16'h8001));
		send_word(enq_word(4, 3, 1'b1, 255, 255, 16'hFFFF));
		repeat (3) send_word(service_word());
	endtask

	// Fill level 3, overflow it, then drain it in one service word
	task automatic test_level3_drain_and_full();
		int i;
		for (i = 0; i < DEPTH; i++)
			send_word(enq_word(3, i % 4, i[0], i * 31, 255 - i * 17, i * 16'h1111));
		send_word(enq_word(3, 1, 1'b1, 1, 2, 3));
		send_word(service_word());
		send_word(service_word());
	endtask

	// Random mix of enqueue and service words
	task automatic test_random_traffic(int count, int enq_pct, int gap_pct, int stall_pct);
		int i;
		req_gap_pct   = gap_pct;
		rsp_stall_pct = stall_pct;
		for (i = 0; i < count; i++)
			send_word(random_word(enq_pct));
	endtask

	// Result side: random back-pressure with stall runs
	initial begin : drive_rsp_ready
		int stall_left;
		stall_left = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else if ($urandom_range(99) < rsp_stall_pct) begin
				stall_left = gap_length() - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			$display("%0t: mismatch on %s: expected %0h, actual %0h", $realtime, name, want, got);
			error_count++;
		end
	endtask

	// Check each accepted result word against the oldest expectation
	always @(posedge clk) begin : check_results
		fpqs_pkg::rsp_t want;
		fpqs_pkg::rsp_t got;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got = rsp_ch.data;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result word, expected none, actual %h", $realtime, got);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				compare_field("status", 16'(want.status), 16'(got.status));
				compare_field("served_priority", 16'(want.served_priority),
					16'(got.served_priority));
				compare_field("out_type", 16'(want.out_type), 16'(got.out_type));
				compare_field("out_mode", 16'(want.out_mode), 16'(got.out_mode));
				compare_field("out_x", 16'(want.out_x), 16'(got.out_x));
				compare_field("out_y", 16'(want.out_y), 16'(got.out_y));
				compare_field("out_handle", want.out_handle, got.out_handle);
				compare_field("switch_refresh", 16'(want.switch_refresh),
					16'(got.switch_refresh));
				compare_field("last", 16'(want.last), 16'(got.last));
				results_checked++;
			end
		end
	end

	// Count cycles with no word moving on either channel
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin : watchdog
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("%0t: no progress for %0d cycles, %0d results outstanding",
			$realtime, WATCHDOG_LIMIT, pending_results.size());
		$display("four_level_priority_queue_scheduler verification failed");
		$finish;
	end

	initial begin : run_tests
		int qi;
		arst_n        = 1'b0;
		req_ch.valid  = 1'b0;
		req_ch.data   = '0;
		error_count   = 0;
		words_sent    = 0;
		results_checked = 0;
		level3_drains = 0;
		full_rejects  = 0;
		req_gap_pct   = 30;
		rsp_stall_pct = 30;
		last_mode     = 1'b0;
		for (qi = 0; qi < fpqs_pkg::NUM_QUEUES; qi++) begin
			head_ptr[qi]  = 0;
			tail_ptr[qi]  = 0;
			occupancy[qi] = 0;
		end

		// Hold reset, release on a falling edge
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_and_bad_priority();
		test_strict_order();
		test_level3_drain_and_full();
		test_random_traffic(150, 70, 35, 35);
		wait_drained();
		test_random_traffic(150, 45, 0, 0);
		test_random_traffic(200, 60, 20, 60);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d request words, checked %0d result words.",
			words_sent, results_checked);
		$display("Saw %0d level-3 drains and %0d full-queue rejects.",
			level3_drains, full_rejects);
		if (error_count == 0 && pending_results.size() == 0)
			$display("four_level_priority_queue_scheduler verification clean");
		else
			$display("four_level_priority_queue_scheduler verification failed");
		$finish;
	end
endmodule
